// ===== hdl/spq_pkg.sv =====
// Shared types and codes for the sorted min-priority queue.
// No dependencies; used by spq_cell and sorted_min_priority_queue.
package spq_pkg;

  localparam int ValueWidth = 32;

  typedef logic signed [ValueWidth-1:0] value_t;
  typedef logic [1:0] action_t;
  typedef logic [1:0] status_t;

  localparam action_t ACT_PUSH = 2'd0;
  localparam action_t ACT_POP  = 2'd1;
  localparam action_t ACT_PEEK = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

// ===== hdl/spq_cell.sv =====
// One storage cell of the sorted chain: holds a value, compares it with the
// broadcast push value and takes its left or right neighbor on a shift.
// Depends on spq_pkg.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::value_t    push_value,
  input  logic               valid,
  input  spq_pkg::value_t    prev_value,
  input  logic               prev_lt,
  input  spq_pkg::value_t    next_value,
  output spq_pkg::value_t    value,
  output logic               lt
);
  import spq_pkg::*;

  value_t value_r;
  value_t value_nxt;

  // Only stored entries count as smaller than the incoming value.
  assign lt = valid && (value_r < push_value);

  always_comb begin
    value_nxt = value_r;
    if (ctrl.push) begin
      if (lt) begin
        value_nxt = value_r;
      end else if (prev_lt) begin
        value_nxt = push_value;
      end else begin
        value_nxt = prev_value;
      end
    end else if (ctrl.pop) begin
      value_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

// ===== hdl/sorted_min_priority_queue.sv =====
// Top level of the sorted min-priority queue: a row of spq_cell instances
// kept in ascending order, an entry counter and a registered result stage.
// Depends on spq_pkg and spq_cell.
//
// Usage: each input item carries an action in in_tuser (push, pop, peek; the
// unused code acts as a peek) and a signed 32-bit value in in_tdata. Every
// accepted item yields exactly one result item: the smallest stored value
// after the operation (0 when empty) in out_tdata, plus empty, full and a
// status code in out_tuser.
// On a push, every cell compares its own value with the broadcast value in
// parallel and either holds, takes the new value or takes its left neighbor.
// A pop shifts every cell one place toward the head.
// The result appears on out_tvalid in the cycle after acceptance, and the
// queue takes one item per cycle while the receiver does not stall; the single
// compare per cell sets that rate.
// Reset clears the entry counter and the result valid flag; cell contents are
// not reset, as only cells below the count are ever read.
// When the receiver stalls, the result register holds its item and in_tready
// drops, so no further item is taken until the result has been taken.
module sorted_min_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] top_value
  output logic [3:0]  out_tuser   // [0] empty_res, [1] full_res, [3:2] status
);
  import spq_pkg::*;

  localparam int CountWidth = $clog2(CAPACITY + 1);

  logic [CountWidth-1:0] count_r;
  logic [CountWidth-1:0] count_nxt;
  logic                  out_valid_r;
  value_t                out_data_r;
  value_t                out_data_nxt;
  logic [3:0]            out_user_r;
  logic [3:0]            out_user_nxt;

  logic       accept;
  action_t    action;
  value_t     push_value;
  logic       is_full;
  logic       is_empty;
  status_t    status;
  cell_ctrl_t ctrl;

  value_t cell_value [CAPACITY];
  logic   cell_lt    [CAPACITY];
  logic   cell_valid [CAPACITY];

  // The result register frees up in the same cycle it is drained.
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign action     = in_tuser;
  assign push_value = in_tdata;

  assign is_full  = (count_r == CountWidth'(CAPACITY));
  assign is_empty = (count_r == '0);

  always_comb begin
    ctrl      = '0;
    status    = ST_OK;
    count_nxt = count_r;
    unique case (action)
      ACT_PUSH: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          ctrl.push = accept;
          count_nxt = count_r + 1'b1;
        end
      end
      ACT_POP: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          ctrl.pop  = accept;
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // The chain: cell 0 is the head, the smallest stored value.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_valid[i] = (count_r > CountWidth'(i));

    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .push_value (push_value),
        .valid      (cell_valid[i]),
        .prev_value (push_value),
        .prev_lt    (1'b1),
        .next_value (cell_value[i+1]),
        .value      (cell_value[i]),
        .lt         (cell_lt[i])
      );
    end else if (i == CAPACITY - 1) begin : g_tail
      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .push_value (push_value),
        .valid      (cell_valid[i]),
        .prev_value (cell_value[i-1]),
        .prev_lt    (cell_lt[i-1]),
        .next_value (cell_value[i]),
        .value      (cell_value[i]),
        .lt         (cell_lt[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .push_value (push_value),
        .valid      (cell_valid[i]),
        .prev_value (cell_value[i-1]),
        .prev_lt    (cell_lt[i-1]),
        .next_value (cell_value[i+1]),
        .value      (cell_value[i]),
        .lt         (cell_lt[i])
      );
    end
  end

  // The head after the operation, worked out from the current head so the
  // result is ready in the same edge that updates the chain.
  always_comb begin
    out_data_nxt = '0;
    if (ctrl.push) begin
      out_data_nxt = cell_lt[0] ? cell_value[0] : push_value;
    end else if (ctrl.pop) begin
      out_data_nxt = (count_r > CountWidth'(1)) ? cell_value[1] : '0;
    end else if (!is_empty) begin
      out_data_nxt = cell_value[0];
    end
    out_user_nxt = {status, (count_nxt == CountWidth'(CAPACITY)), (count_nxt == '0)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
